>>> hdl/cholesky_factorizer_core_defines.svh
// Assertion macros used by the checker file chf_checker.sv.
`ifndef CHOLESKY_FACTORIZER_CORE_DEFINES_SVH
`define CHOLESKY_FACTORIZER_CORE_DEFINES_SVH

// Implication that must hold at every clock edge out of reset.
`define CHF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Implication whose consequent is sampled in the cycle after the antecedent.
`define CHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> hdl/chf_pkg.sv
`default_nettype none
package chf_pkg;
    localparam int MaxDimDefault = 8;
    localparam int DataW         = 32;
    localparam int AccW          = 64;
    localparam int DimW          = 4;

    typedef logic signed [DataW-1:0] data_t;
    typedef logic signed [AccW-1:0]  acc_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_ELEM,
        ST_SQRT,
        ST_DIV,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
        acc_t operand;
        data_t divisor;
    } op_req_t;

    typedef struct packed {
        logic  done;
        data_t result;
    } op_rsp_t;

    localparam logic [0:0] REG_DIM = 1'b0;

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        acc_t s;
        s = a + b;
        if (!a[AccW-1] && !b[AccW-1] && s[AccW-1])
            return {1'b0, {(AccW-1){1'b1}}};
        if (a[AccW-1] && b[AccW-1] && !s[AccW-1])
            return {1'b1, {(AccW-1){1'b0}}};
        return s;
    endfunction

    function automatic acc_t sat_sub(input acc_t a, input acc_t b);
        acc_t s;
        s = a - b;
        if (!a[AccW-1] && b[AccW-1] && s[AccW-1])
            return {1'b0, {(AccW-1){1'b1}}};
        if (a[AccW-1] && !b[AccW-1] && !s[AccW-1])
            return {1'b1, {(AccW-1){1'b0}}};
        return s;
    endfunction
endpackage
`default_nettype wire

>>> hdl/chf_stream_if.sv
`default_nettype none
interface chf_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/chf_out_if.sv
`default_nettype none
interface chf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] factor_value;
    logic        factor_last;
    logic        not_pos_def;
    modport source (output valid, output factor_value, output factor_last,
                    output not_pos_def, input ready);
    modport sink   (input valid, input factor_value, input factor_last,
                    input not_pos_def, output ready);
endinterface
`default_nettype wire

>>> hdl/chf_serial_unit.sv
`default_nettype none
// Bit-serial unit: restoring square root (two radicand bits per cycle, one
// result bit) or signed division of a 64-bit dividend by a positive 32-bit
// divisor (one quotient bit per cycle).
module chf_serial_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chf_pkg::op_req_t req,
    output chf_pkg::op_rsp_t      rsp
);
    import chf_pkg::*;

    logic        busy_reg, busy_next;
    logic        sqrt_reg, sqrt_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;      // remaining radicand / dividend shifter
    logic [65:0] rem_reg, rem_next;  // partial remainder
    logic [63:0] q_reg, q_next;      // root / quotient
    logic [31:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [65:0] trial;
    logic [65:0] rsh;
    logic [63:0] qabs;

    always_comb
    begin
        busy_next = busy_reg;
        sqrt_next = sqrt_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = '0;
        rsh       = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            sqrt_next = req.is_sqrt;
            neg_next  = req.operand[63] && !req.is_sqrt;
            x_next    = (req.operand[63] && !req.is_sqrt) ? 64'(-req.operand)
                                                           : 64'(req.operand);
            d_next    = 32'(req.divisor);
            cnt_next  = req.is_sqrt ? 7'd32 : 7'd64;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                rsh   = {rem_reg[63:0], x_reg[63:62]};
                trial = {q_reg[63:0], 2'b01};
                x_next = {x_reg[61:0], 2'b00};
                if (rsh >= trial)
                begin
                    rem_next = rsh - trial;
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
            end
            else
            begin
                rsh    = {rem_reg[64:0], x_reg[63]};
                trial  = {34'd0, d_reg};
                x_next = {x_reg[62:0], 1'b0};
                if (rsh >= trial)
                begin
                    rem_next = rsh - trial;
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
    end

    // Saturate magnitude, then apply sign.
    assign qabs = q_reg;
    always_comb
    begin
        rsp.done = done_reg;
        if (sqrt_reg)
            rsp.result = (qabs > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : data_t'(qabs[31:0]);
        else if (!neg_reg)
            rsp.result = (qabs > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : data_t'(qabs[31:0]);
        else
            rsp.result = (qabs > 64'h8000_0000) ? 32'sh8000_0000
                                               : data_t'(32'(-qabs));
    end
endmodule
`default_nettype wire

>>> hdl/cholesky_factorizer_core.sv
`default_nettype none
// Channel | Dir | Payload
// in_s    | in  | elem_value[31:0] signed Q16.16, row-major
// out_s   | out | factor_value[31:0], factor_last, not_pos_def
// apb     | in  | dim_in_use at byte address 0
//
// Loading takes one element per cycle while no APB write is pending. After the
// last element the factor is computed entry by entry: a dot product whose terms
// each pass the read, multiply and accumulate states, then the serial square
// root (diagonal) or the serial divider. Results leave through a registered
// output; a stalled output holds the word. rst_n is asynchronous.
module cholesky_factorizer_core #(
    parameter int MAX_DIM = chf_pkg::MaxDimDefault
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    chf_stream_if.sink                in_s,
    chf_out_if.source                 out_s
);
    import chf_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [DimW-1:0] dim_reg;
    logic [IW-1:0]   row_reg, row_next, col_reg, col_next, k_reg, k_next;
    logic            err_reg, err_next;
    logic [MAX_DIM-1:0] bad_reg, bad_next;
    acc_t            acc_reg, acc_next;
    acc_t            prod_reg;
    data_t           a_rd_reg, l1_rd_reg, l2_rd_reg, diag_reg;
    data_t           res_reg;
    logic            out_valid_reg, out_last_reg, out_err_reg;
    data_t           out_val_reg;
    data_t           a_mem [DEPTH];
    data_t           l_mem [DEPTH];
    logic            wr_a;
    logic [AW-1:0]   a_waddr, l_waddr, rd1, rd2;
    logic            wr_l;
    data_t           l_wdata;
    op_req_t         req;
    op_rsp_t         rsp;
    logic            cfg_wr;
    logic [DimW-1:0] dim_eff;
    logic            last_elem;
    acc_t            t_val;

    assign pready = 1'b1;
    assign prdata = {28'd0, dim_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DimW'(MAX_DIM < 8 ? MAX_DIM : 8);
        else if (cfg_wr)
        begin
            if (pwdata[3:0] == 4'd0)
                dim_reg <= 4'd1;
            else if (32'(pwdata[3:0]) > MAX_DIM)
                dim_reg <= DimW'(MAX_DIM);
            else
                dim_reg <= pwdata[3:0];
        end
    end
    assign dim_eff = dim_reg;

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    assign last_elem = (32'(row_reg) == 32'(dim_eff) - 1) && (32'(col_reg) == 32'(dim_eff) - 1);
    assign t_val     = sat_sub(acc_t'(a_rd_reg) <<< 16, acc_reg);

    assign in_s.ready = (state_reg == ST_LOAD) && !cfg_wr;

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        k_next   = k_reg;
        err_next = err_reg;
        bad_next = bad_reg;
        acc_next = acc_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cfg_wr)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if (in_s.valid)
                begin
                    if (row_reg == '0 && col_reg == '0)
                        err_next = 1'b0;
                    if (last_elem)
                    begin
                        row_next = '0;
                        col_next = '0;
                        k_next   = '0;
                        acc_next = '0;
                        bad_next = '0;
                        state_next = ST_DOT_RD;
                    end
                    else if (32'(col_reg) == 32'(dim_eff) - 1)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            ST_DOT_RD:
                state_next = (k_reg == col_reg) ? ST_ELEM : ST_DOT_MUL;
            ST_DOT_MUL:
                state_next = ST_DOT_ACC;
            ST_DOT_ACC:
            begin
                acc_next = sat_add(acc_reg, prod_reg);
                k_next   = k_reg + 1'b1;
                state_next = ST_DOT_RD;
            end
            ST_ELEM:
            begin
                if (row_reg == col_reg)
                begin
                    if (t_val[AccW-1] || t_val == '0)
                    begin
                        err_next = 1'b1;
                        bad_next[col_reg] = 1'b1;
                        state_next = ST_WRITE;
                    end
                    else
                        state_next = ST_SQRT;
                end
                else if (bad_reg[col_reg] || diag_reg[DataW-1] || diag_reg == '0)
                    state_next = ST_WRITE;
                else
                    state_next = ST_DIV;
            end
            ST_SQRT, ST_DIV:
                if (rsp.done)
                    state_next = ST_WRITE;
            ST_WRITE:
            begin
                k_next   = '0;
                acc_next = '0;
                if (col_reg == row_reg)
                begin
                    col_next = '0;
                    if (32'(row_reg) == 32'(dim_eff) - 1)
                    begin
                        row_next = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        state_next = ST_DOT_RD;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    state_next = ST_DOT_RD;
                end
            end
            ST_EMIT_RD:
                if (!out_valid_reg || out_s.ready)
                    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (last_elem)
                begin
                    row_next = '0;
                    col_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    if (32'(col_reg) == 32'(dim_eff) - 1)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                        col_next = col_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Datapath control outputs.
    always_comb
    begin
        wr_a    = (state_reg == ST_LOAD) && in_s.valid && !cfg_wr && (col_reg <= row_reg);
        a_waddr = addr(row_reg, col_reg);
        wr_l    = (state_reg == ST_WRITE);
        l_waddr = addr(row_reg, col_reg);
        l_wdata = res_reg;
        rd1     = addr(row_reg, k_reg);
        rd2     = (state_reg == ST_DOT_RD || state_reg == ST_DOT_MUL)
                  ? addr(col_reg, k_reg) : addr(col_reg, col_reg);
        if (state_reg == ST_EMIT_RD)
            rd1 = addr(row_reg, col_reg);
        req.start   = (state_reg == ST_ELEM) && (state_next == ST_SQRT || state_next == ST_DIV);
        req.is_sqrt = (row_reg == col_reg);
        req.operand = t_val;
        req.divisor = diag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[a_waddr] <= in_s.data;
        if (wr_l)
            l_mem[l_waddr] <= l_wdata;
        l1_rd_reg <= l_mem[rd1];
        l2_rd_reg <= l_mem[rd2];
        a_rd_reg  <= a_mem[addr(row_reg, col_reg)];
    end

    assign diag_reg = l2_rd_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= acc_t'(l1_rd_reg) * acc_t'(l2_rd_reg);
        acc_reg  <= acc_next;
        if (state_reg == ST_ELEM)
            res_reg <= '0;
        else if ((state_reg == ST_SQRT || state_reg == ST_DIV) && rsp.done)
            res_reg <= rsp.result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            row_reg <= '0;
            col_reg <= '0;
            k_reg   <= '0;
            err_reg <= 1'b0;
            bad_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            k_reg   <= k_next;
            err_reg <= err_next;
            bad_reg <= bad_next;
            if (state_reg == ST_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_s.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            out_val_reg  <= (col_reg <= row_reg) ? l1_rd_reg : '0;
            out_last_reg <= last_elem;
            out_err_reg  <= err_reg;
        end
    end

    chf_serial_unit u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign out_s.valid        = out_valid_reg;
    assign out_s.factor_value = out_val_reg;
    assign out_s.factor_last  = out_last_reg;
    assign out_s.not_pos_def  = out_err_reg;
endmodule
`default_nettype wire

>>> hdl/chf_checker.sv
`default_nettype none
`include "cholesky_factorizer_core_defines.svh"
module chf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last,
    input wire logic out_err,
    input wire logic pready
);
    // Only the final word of a burst may wait while the next matrix loads.
    `CHF_ASSERT_IMPL(a_no_load_while_emit, clk, rst_n, out_valid && !out_last, !in_ready)
    `CHF_ASSERT_NEXT(a_hold_stall, clk, rst_n, out_valid && !out_ready, out_valid)
    `CHF_ASSERT_IMPL(a_pready_high, clk, rst_n, 1'b1, pready)
    `CHF_ASSERT_NEXT(a_err_steady, clk, rst_n, out_valid && out_ready && !out_last,
        !out_valid || out_err == $past(out_err))
endmodule

bind cholesky_factorizer_core chf_checker u_chf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_last  (out_s.factor_last),
    .out_err   (out_s.not_pos_def),
    .pready    (pready)
);
`default_nettype wire

>>> verif/cholesky_factorizer_checker.sv
`timescale 1ns / 1ps
module cholesky_factorizer_checker #(
    parameter int MAX_DIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        elem_fire,
    input  logic [31:0] elem_word,
    input  logic        factor_fire,
    input  logic [31:0] factor_word,
    input  logic        factor_last_in,
    input  logic        not_pos_def_in,
    input  logic        dim_write,
    input  logic [3:0]  dim_word,
    output int          fail_count,
    output int          pending_count,
    output int          factor_count,
    output int          matrix_count,
    output int          error_matrices
);
    import chf_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        npd;
    } factor_word_t;

    factor_word_t factor_queue[$];
    logic signed [31:0] lower_store[MAX_DIM*MAX_DIM];
    int unsigned order_n;
    int unsigned elems_loaded;
    logic        error_flag;

    assign pending_count = factor_queue.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rem;
        root = 0;
        rem = x;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] wide;
        wide = 65'(a) + 65'(b);
        if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (wide < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return wide[63:0];
    endfunction

    task automatic factorize_and_queue();
        logic signed [31:0] fac[MAX_DIM*MAX_DIM];
        logic               col_bad[MAX_DIM];
        logic signed [63:0] dot;
        logic signed [63:0] resid;
        logic signed [63:0] quot;
        logic [63:0]        root;
        factor_word_t       w;
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++)
            fac[i] = 0;
        for (int i = 0; i < MAX_DIM; i++)
            col_bad[i] = 0;
        for (int r = 0; r < order_n; r++)
            for (int c = 0; c <= r; c++)
            begin
                dot = 0;
                for (int k = 0; k < c; k++)
                    dot = add_clip(dot, 64'(fac[r*MAX_DIM+k]) * 64'(fac[c*MAX_DIM+k]));
                resid = add_clip(64'(lower_store[r*MAX_DIM+c]) <<< 16, -dot);
                // negating the minimum would wrap; clip the difference directly
                if (dot == 64'sh8000_0000_0000_0000)
                    resid = (lower_store[r*MAX_DIM+c] < 0) ?
                        (64'(lower_store[r*MAX_DIM+c]) <<< 16) + 64'sh7FFF_FFFF_FFFF_FFFF + 1
                        : 64'sh7FFF_FFFF_FFFF_FFFF;
                if (r == c)
                begin
                    if (resid <= 0)
                    begin
                        fac[r*MAX_DIM+c] = 0;
                        col_bad[c] = 1;
                        error_flag = 1;
                    end
                    else
                    begin
                        root = int_sqrt(resid);
                        fac[r*MAX_DIM+c] = (root > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : root[31:0];
                    end
                end
                else if (col_bad[c] || fac[c*MAX_DIM+c] <= 0)
                    fac[r*MAX_DIM+c] = 0;
                else
                begin
                    quot = resid / 64'(fac[c*MAX_DIM+c]);
                    if (quot > 64'sh7FFF_FFFF)
                        fac[r*MAX_DIM+c] = 32'sh7FFF_FFFF;
                    else if (quot < -64'sh8000_0000)
                        fac[r*MAX_DIM+c] = 32'sh8000_0000;
                    else
                        fac[r*MAX_DIM+c] = quot[31:0];
                end
            end
        for (int r = 0; r < order_n; r++)
            for (int c = 0; c < order_n; c++)
            begin
                w.value = (c <= r) ? fac[r*MAX_DIM+c] : 32'd0;
                w.last = (r == order_n - 1) && (c == order_n - 1);
                w.npd = error_flag;
                factor_queue = {factor_queue, w};
            end
        matrix_count++;
        if (error_flag)
            error_matrices++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        factor_word_t want;
        int unsigned  row;
        int unsigned  col;
        if (!rst_n)
        begin
            order_n = MAX_DIM;
            elems_loaded = 0;
            error_flag = 0;
            fail_count = 0;
            factor_count = 0;
            matrix_count = 0;
            error_matrices = 0;
            factor_queue.delete();
        end
        else
        begin
            if (dim_write)
            begin
                order_n = (dim_word == 0) ? 1 : (dim_word > MAX_DIM) ? MAX_DIM : dim_word;
                elems_loaded = 0;
            end
            if (elem_fire)
            begin
                if (elems_loaded >= order_n * order_n)
                    elems_loaded = 0;
                if (elems_loaded == 0)
                    error_flag = 0;
                row = elems_loaded / order_n;
                col = elems_loaded % order_n;
                if (col <= row)
                    lower_store[row*MAX_DIM+col] = elem_word;
                elems_loaded++;
                if (elems_loaded == order_n * order_n)
                begin
                    elems_loaded = 0;
                    factorize_and_queue();
                end
            end
            if (factor_fire)
            begin
                factor_count++;
                if (factor_queue.size() == 0)
                    report_mismatch("unexpected factor word", factor_word, 32'd0);
                else
                begin
                    want = factor_queue.pop_front();
                    if (factor_word !== want.value)
                        report_mismatch("factor_value", factor_word, want.value);
                    if (factor_last_in !== want.last)
                        report_mismatch("factor_last", 32'(factor_last_in), 32'(want.last));
                    if (not_pos_def_in !== want.npd)
                        report_mismatch("not_pos_def", 32'(not_pos_def_in), 32'(want.npd));
                end
            end
        end
    end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import chf_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          factor_count;
    int          matrix_count;
    int          error_matrices;
    int          idle_cycles;
    int          sent_items;
    logic        hold_off;
    logic        stimulus_done;

    chf_stream_if #(.W(32)) in_s ();
    chf_out_if              out_s ();

    cholesky_factorizer_core #(.MAX_DIM(MAX_DIM)) dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_s(in_s.sink), .out_s(out_s.source)
    );

    cholesky_factorizer_checker #(.MAX_DIM(MAX_DIM)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .elem_fire(in_s.valid && in_s.ready), .elem_word(in_s.data),
        .factor_fire(out_s.valid && out_s.ready), .factor_word(out_s.factor_value),
        .factor_last_in(out_s.factor_last), .not_pos_def_in(out_s.not_pos_def),
        .dim_write(psel && penable && pwrite && pready && paddr == {REG_DIM, 2'b00}),
        .dim_word(pwdata[3:0]),
        .fail_count(fail_count), .pending_count(pending_count),
        .factor_count(factor_count), .matrix_count(matrix_count),
        .error_matrices(error_matrices)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_s.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_s.ready <= 1'b0;
            else if (stimulus_done || $urandom_range(0, 3) != 0)
                out_s.ready <= ($urandom_range(0, 4) != 0);
            else
                out_s.ready <= (gap_len() == 0);
        end
    end

    // leaves valid high on return; drop it after the last word of a group
    task automatic send_elem(input logic [31:0] v);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_s.valid <= 1'b0;
            repeat (g)
                @(negedge clk);
        end
        in_s.valid <= 1'b1;
        in_s.data <= v;
        @(posedge clk);
        while (!in_s.ready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic write_dim(input logic [3:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_DIM, 2'b00};
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (pending_count != 0)
            @(posedge clk);
        repeat (3000)
            @(posedge clk);
    endtask

    // well-conditioned in mode 0: diagonal dominant, random small off-diagonals
    task automatic send_spd(input int n, input int mode);
        logic [31:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                if (c > r)
                    v = $urandom;
                else if (r == c)
                    v = (mode == 1 && $urandom_range(0, 2) == 0) ? -$urandom_range(0, 65536)
                        : 32'($urandom_range(n * 65536, 32'h7FFF_FFFF));
                else if (mode == 2)
                    v = $urandom;
                else
                    v = 32'(int'($urandom_range(0, 2 * 65536)) - 65536);
                send_elem(v);
            end
    endtask

    initial
    begin
        int n;
        in_s.valid = 1'b0;
        in_s.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        stimulus_done = 1'b0;
        sent_items = 0;
        rst_n = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset order is eight; extremes in one matrix
        send_elem(32'h7FFF_FFFF);
        for (int i = 1; i < 64; i++)
            send_elem((i % 9 == 0) ? 32'h4000_0000 : (i % 2) ? 32'h8000_0000 : 32'h0000_0001);
        in_s.valid <= 1'b0;
        drain_and_settle();
        write_dim(4'd0);
        send_elem(32'h0001_0000);
        send_elem(32'h0000_0000);
        send_elem(32'hFFFF_0000);
        in_s.valid <= 1'b0;
        drain_and_settle();
        write_dim(4'd15);
        send_spd(MAX_DIM, 0);
        in_s.valid <= 1'b0;
        drain_and_settle();
        write_dim(4'd2);
        send_elem(32'h0004_0000);
        send_elem(32'h1234_5678);
        in_s.valid <= 1'b0;
        // abandon a partial load with a register write
        drain_and_settle();
        write_dim(4'd3);
        send_elem(32'h0000_0000);
        send_elem(32'h0000_0000);
        send_elem(32'h0000_0000);
        send_elem(32'h0001_0000);
        send_elem(32'h0002_0000);
        send_elem(32'h0000_0000);
        send_elem(32'h0001_0000);
        send_elem(32'h0000_0000);
        send_elem(32'h0003_0000);
        in_s.valid <= 1'b0;
        drain_and_settle();

        // hold the receiver while the sender keeps pushing
        write_dim(4'd4);
        fork
            begin
                hold_off = 1'b1;
                repeat (2500)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 4; m++)
                    send_spd(4, 0);
                in_s.valid <= 1'b0;
            end
        join
        drain_and_settle();

        while (sent_items < 340)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            write_dim(4'(n));
            for (int m = 0; m < 3; m++)
                send_spd(n, ($urandom_range(0, 4) == 0) ? 1 : ($urandom_range(0, 7) == 0) ? 2 : 0);
            in_s.valid <= 1'b0;
            drain_and_settle();
        end
        stimulus_done = 1'b1;
        drain_and_settle();
        $display("covered %0d matrices (%0d flagged not positive definite), %0d factor words",
                 matrix_count, error_matrices, factor_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_s.valid && in_s.ready) || (out_s.valid && out_s.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end
endmodule

>>> files.f
+incdir+hdl
hdl/chf_pkg.sv
hdl/chf_stream_if.sv
hdl/chf_out_if.sv
hdl/chf_serial_unit.sv
hdl/cholesky_factorizer_core.sv
hdl/chf_checker.sv
verif/cholesky_factorizer_checker.sv
verif/tb.sv
